// ===== hw/rtl/i2c_master_bit_engine_core_defines.svh =====
// Assertion macros shared by the checker files of the I2C master bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define I2CMBE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, masked while reset is high.
`define I2CMBE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication that also holds through reset.
`define I2CMBE_ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/i2cmbe_pkg.sv =====
// Types and constants of the I2C master bit engine.
`timescale 1ns / 1ps

package i2cmbe_pkg;

  // Running sequence; codes match the command codes that start them
  typedef enum logic [2:0] {
    OP_IDLE      = 3'd0,
    OP_START     = 3'd1,
    OP_STOP      = 3'd2,
    OP_WRITE     = 3'd3,
    OP_READ_ACK  = 3'd4,
    OP_READ_NACK = 3'd5,
    OP_WAIT      = 3'd6
  } op_t;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_LAST     = 3'd6;
  localparam logic [7:0] LIMIT_RESET  = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // One input item
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] write_byte;
    logic       sda_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_fail;
  } res_t;

endpackage

// ===== hw/rtl/i2c_master_bit_engine_core.sv =====
// Each item is registered at the input; its result is registered at the output.
// Throughput: one item per clock unless stalled; one bus phase per tick item.
// An input register and the output register decouple the two channels.
// Reset (rst, synchronous): bus idle high, driving, sequence idle, limit 250.
// The configuration write is taken every cycle; no clearing pass is needed.
`timescale 1ns / 1ps

module i2c_master_bit_engine_core (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  // input items
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] cmd,
  input  logic [7:0] write_byte,
  input  logic       sda_in,
  // result items
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       sda_drive,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_byte,
  output logic       ack_fail
);

  logic [7:0]         ack_timeout_limit;
  i2cmbe_pkg::item_t  item_reg;
  logic               item_valid;
  i2cmbe_pkg::res_t   res_next;
  i2cmbe_pkg::res_t   res_reg;
  logic               out_free;
  logic               fire;

  assign cfg_ready = 1'b1;

  // Hold the timeout limit
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_limit <= i2cmbe_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ack_timeout_limit <= cfg_data;
    end
  end

  // Pipeline control: the output slot frees when empty or taken
  assign out_free = !out_valid || !out_stall;
  assign fire     = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_reg.cmd        <= cmd;
      item_reg.write_byte <= write_byte;
      item_reg.sda_in     <= sda_in;
    end
  end

  i2cmbe_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (item_reg),
    .limit (ack_timeout_limit),
    .res   (res_next)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_reg <= res_next;
    end
  end

  assign scl_level = res_reg.scl_level;
  assign sda_level = res_reg.sda_level;
  assign sda_drive = res_reg.sda_drive;
  assign busy_res  = res_reg.busy_res;
  assign done_res  = res_reg.done_res;
  assign read_byte = res_reg.read_byte;
  assign ack_fail  = res_reg.ack_fail;

endmodule

// ===== hw/rtl/i2cmbe_seq.sv =====
// Phase sequencer of the I2C master bit engine: bus state and its update per item.
`timescale 1ns / 1ps

module i2cmbe_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  i2cmbe_pkg::item_t  item,
  input  logic [7:0]         limit,
  output i2cmbe_pkg::res_t   res
);

  i2cmbe_pkg::op_t operation, operation_next;
  logic [1:0] phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shifter, shifter_next;
  logic [7:0] poll_count, poll_count_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;
  logic       sda_dir, sda_dir_next;
  logic       fail_flag, fail_flag_next;
  logic [7:0] rx_byte, rx_byte_next;
  logic       done;
  logic [3:0] bit_inc;
  logic [8:0] poll_inc;

  assign bit_inc  = bit_count + 4'd1;
  assign poll_inc = {1'b0, poll_count} + 9'd1;

  // Work out the state after this item
  always_comb begin
    operation_next  = operation;
    phase_next      = phase;
    bit_count_next  = bit_count;
    shifter_next    = shifter;
    poll_count_next = poll_count;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    sda_dir_next    = sda_dir;
    fail_flag_next  = fail_flag;
    rx_byte_next    = rx_byte;
    done            = 1'b0;

    if (item.cmd == i2cmbe_pkg::CMD_TICK) begin
      // advance the running sequence by one phase
      case (operation)
        i2cmbe_pkg::OP_START: begin
          if (phase == 2'd0) begin
            sda_reg_next = 1'b0;
            phase_next   = 2'd1;
          end else begin
            scl_reg_next   = 1'b0;
            operation_next = i2cmbe_pkg::OP_IDLE;
            phase_next     = 2'd0;
            done           = 1'b1;
          end
        end
        i2cmbe_pkg::OP_STOP: begin
          if (phase == 2'd0) begin
            scl_reg_next = 1'b1;
            phase_next   = 2'd1;
          end else begin
            sda_reg_next   = 1'b1;
            operation_next = i2cmbe_pkg::OP_IDLE;
            phase_next     = 2'd0;
            done           = 1'b1;
          end
        end
        i2cmbe_pkg::OP_WRITE: begin
          if (phase == 2'd0) begin
            sda_reg_next = shifter[7];
            shifter_next = {shifter[6:0], 1'b0};
            phase_next   = 2'd1;
          end else if (phase == 2'd1) begin
            scl_reg_next = 1'b1;
            phase_next   = 2'd2;
          end else begin
            scl_reg_next = 1'b0;
            phase_next   = 2'd0;
            if (bit_inc >= i2cmbe_pkg::BITS_PER_BYTE) begin
              operation_next = i2cmbe_pkg::OP_IDLE;
              bit_count_next = 4'd0;
              done           = 1'b1;
            end else begin
              bit_count_next = bit_inc;
            end
          end
        end
        i2cmbe_pkg::OP_READ_ACK, i2cmbe_pkg::OP_READ_NACK: begin
          if (bit_count < i2cmbe_pkg::BITS_PER_BYTE) begin
            // data bits: sample on the SCL rise
            if (phase == 2'd0) begin
              scl_reg_next = 1'b1;
              shifter_next = {shifter[6:0], item.sda_in};
              phase_next   = 2'd1;
            end else begin
              scl_reg_next   = 1'b0;
              phase_next     = 2'd0;
              bit_count_next = bit_inc;
            end
          end else if (phase == 2'd0) begin
            // drive the acknowledge bit
            sda_dir_next = 1'b1;
            sda_reg_next = (operation == i2cmbe_pkg::OP_READ_NACK);
            phase_next   = 2'd1;
          end else if (phase == 2'd1) begin
            scl_reg_next = 1'b1;
            phase_next   = 2'd2;
          end else begin
            scl_reg_next   = 1'b0;
            phase_next     = 2'd0;
            bit_count_next = 4'd0;
            rx_byte_next   = shifter;
            operation_next = i2cmbe_pkg::OP_IDLE;
            done           = 1'b1;
          end
        end
        i2cmbe_pkg::OP_WAIT: begin
          if (phase == 2'd0) begin
            scl_reg_next = 1'b1;
            phase_next   = 2'd1;
          end else if (!item.sda_in) begin
            scl_reg_next   = 1'b0;
            operation_next = i2cmbe_pkg::OP_IDLE;
            phase_next     = 2'd0;
            done           = 1'b1;
          end else if (poll_inc > {1'b0, limit}) begin
            // timed out: flag and turn into a STOP
            fail_flag_next = 1'b1;
            operation_next = i2cmbe_pkg::OP_STOP;
            phase_next     = 2'd0;
            sda_dir_next   = 1'b1;
            scl_reg_next   = 1'b0;
            sda_reg_next   = 1'b0;
          end else begin
            poll_count_next = poll_inc[7:0];
          end
        end
        default: begin
          // idle: a tick changes nothing
        end
      endcase
    end else if (item.cmd <= i2cmbe_pkg::CMD_LAST
                 && operation == i2cmbe_pkg::OP_IDLE) begin
      // take a new command and set the first line levels
      fail_flag_next = 1'b0;
      phase_next     = 2'd0;
      bit_count_next = 4'd0;
      operation_next = i2cmbe_pkg::op_t'(item.cmd);
      case (i2cmbe_pkg::op_t'(item.cmd))
        i2cmbe_pkg::OP_START: begin
          sda_dir_next = 1'b1;
          sda_reg_next = 1'b1;
          scl_reg_next = 1'b1;
        end
        i2cmbe_pkg::OP_STOP: begin
          sda_dir_next = 1'b1;
          scl_reg_next = 1'b0;
          sda_reg_next = 1'b0;
        end
        i2cmbe_pkg::OP_WRITE: begin
          sda_dir_next = 1'b1;
          scl_reg_next = 1'b0;
          shifter_next = item.write_byte;
        end
        i2cmbe_pkg::OP_READ_ACK, i2cmbe_pkg::OP_READ_NACK: begin
          sda_dir_next = 1'b0;
          scl_reg_next = 1'b0;
          shifter_next = 8'd0;
        end
        default: begin
          sda_dir_next    = 1'b0;
          sda_reg_next    = 1'b1;
          poll_count_next = 8'd0;
        end
      endcase
    end
  end

  // Hold the bus state, update on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      operation  <= i2cmbe_pkg::OP_IDLE;
      phase      <= 2'd0;
      bit_count  <= 4'd0;
      shifter    <= 8'd0;
      poll_count <= 8'd0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      sda_dir    <= 1'b1;
      fail_flag  <= 1'b0;
      rx_byte    <= 8'd0;
    end else if (fire) begin
      operation  <= operation_next;
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shifter    <= shifter_next;
      poll_count <= poll_count_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      sda_dir    <= sda_dir_next;
      fail_flag  <= fail_flag_next;
      rx_byte    <= rx_byte_next;
    end
  end

  // Result seen after this item
  always_comb begin
    res.scl_level = scl_reg_next;
    res.sda_level = sda_reg_next;
    res.sda_drive = sda_dir_next;
    res.busy_res  = (operation_next != i2cmbe_pkg::OP_IDLE);
    res.done_res  = done;
    res.read_byte = rx_byte_next;
    res.ack_fail  = fail_flag_next;
  end

endmodule

// ===== hw/rtl/i2cmbe_chk.sv =====
// Port-level checker of the I2C master bit engine and its bind.
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_core_defines.svh"

module i2cmbe_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       scl_level,
  input logic       sda_level,
  input logic       sda_drive,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_byte,
  input logic       ack_fail
);

  // a stalled result holds its payload
  `I2CMBE_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(read_byte) && $stable(scl_level)
                     && $stable(sda_level) && $stable(done_res))

  // a finished sequence never reports busy
  `I2CMBE_ASSERT_IMP(a_done_idle, out_valid && done_res, !busy_res)

  // after a failed ack wait the master drives SDA for the STOP
  `I2CMBE_ASSERT_IMP(a_fail_drive, out_valid && ack_fail, sda_drive)

  // an empty result slot never stalls the input
  `I2CMBE_ASSERT_IMP(a_in_free, in_valid && !out_valid, !in_stall)

  // reset empties the result register
  `I2CMBE_ASSERT_NXT_RST(a_rst_empty, rst, !out_valid)

endmodule

bind i2c_master_bit_engine_core i2cmbe_chk u_i2cmbe_chk (.*);

// ===== tb/sv/tb_i2c_master_bit_engine_core.sv =====
// Self-checking testbench for the I2C master bit engine core.
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine_core;

  localparam logic [2:0] CMD_RSVD = 3'd7;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 128;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int WDOG_LIMIT = 2000;
  localparam int DIR_ROWS = 21;
  localparam int ACK_NEVER = 1000;

  localparam i2cmbe_pkg::res_t IDLE_LINES = '{scl_level: 1'b1, sda_level: 1'b1,
                                              sda_drive: 1'b1, busy_res: 1'b0,
                                              done_res: 1'b0, read_byte: 8'h00,
                                              ack_fail: 1'b0};
  localparam i2cmbe_pkg::res_t START_LINES = '{scl_level: 1'b1, sda_level: 1'b1,
                                               sda_drive: 1'b1, busy_res: 1'b1,
                                               done_res: 1'b0, read_byte: 8'h00,
                                               ack_fail: 1'b0};

  // One directed row; want is only used where pinned is set
  typedef struct packed {
    logic [2:0]       cmd;
    logic [7:0]       wbyte;
    logic             sda;
    logic             pinned;
    i2cmbe_pkg::res_t want;
  } step_row_t;

  localparam step_row_t DIR_TAB [DIR_ROWS] = '{
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b0, 1'b1, IDLE_LINES},
    '{CMD_RSVD,                 8'hFF, 1'b1, 1'b1, IDLE_LINES},
    '{i2cmbe_pkg::OP_START,     8'h00, 1'b1, 1'b1, START_LINES},
    '{i2cmbe_pkg::OP_WRITE,     8'hFF, 1'b1, 1'b1, START_LINES},
    '{CMD_RSVD,                 8'h00, 1'b0, 1'b1, START_LINES},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b0, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b1, 1'b0, '0},
    '{i2cmbe_pkg::OP_STOP,      8'h00, 1'b0, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b1, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b0, 1'b0, '0},
    '{i2cmbe_pkg::OP_WAIT,      8'h00, 1'b1, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b1, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b1, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b1, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b0, 1'b0, '0},
    '{i2cmbe_pkg::OP_READ_ACK,  8'h5A, 1'b0, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b1, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b1, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b0, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b1, 1'b0, '0},
    '{i2cmbe_pkg::CMD_TICK,     8'h00, 1'b0, 1'b0, '0}
  };

  // Ack timeout per phase; phase 0 keeps the reset value, phase 3 is drawn at random
  localparam logic [7:0] CFG_PLAN [PHASES] = '{8'd250, 8'd0, 8'd255, 8'd0, 8'd1, 8'd3};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] cmd = i2cmbe_pkg::CMD_TICK;
  logic [7:0] write_byte = 8'h00;
  logic       sda_in = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_fail;

  // Predicted engine state
  i2cmbe_pkg::op_t op_p;
  logic [1:0] ph_p;
  logic [3:0] nbits_p;
  logic [7:0] sh_p;
  logic [7:0] polls_p;
  logic [7:0] rx_p;
  logic [7:0] limit_p;
  logic       scl_p;
  logic       sda_p;
  logic       drv_p;
  logic       fail_p;

  i2cmbe_pkg::res_t want_lines [$];
  int   errors = 0;
  int   quiet = 0;
  bit   gap_on = 1'b1;
  bit   stall_on = 1'b1;
  bit   hold_req = 1'b0;

  i2c_master_bit_engine_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .write_byte (write_byte),
    .sda_in     (sda_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .sda_drive  (sda_drive),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .read_byte  (read_byte),
    .ack_fail   (ack_fail)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one item to the predicted state and return the bus lines after it
  function automatic i2cmbe_pkg::res_t bus_step(logic [2:0] c, logic [7:0] b, logic s);
    logic fin;
    i2cmbe_pkg::res_t r;
    fin = 1'b0;
    if (c == i2cmbe_pkg::CMD_TICK && op_p != i2cmbe_pkg::OP_IDLE) begin
      case (op_p)
        i2cmbe_pkg::OP_START: begin
          if (ph_p == 2'd0) begin
            sda_p = 1'b0;
            ph_p = 2'd1;
          end else begin
            scl_p = 1'b0;
            op_p = i2cmbe_pkg::OP_IDLE;
            ph_p = 2'd0;
            fin = 1'b1;
          end
        end
        i2cmbe_pkg::OP_STOP: begin
          if (ph_p == 2'd0) begin
            scl_p = 1'b1;
            ph_p = 2'd1;
          end else begin
            sda_p = 1'b1;
            op_p = i2cmbe_pkg::OP_IDLE;
            ph_p = 2'd0;
            fin = 1'b1;
          end
        end
        i2cmbe_pkg::OP_WRITE: begin
          if (ph_p == 2'd0) begin
            sda_p = sh_p[7];
            sh_p = {sh_p[6:0], 1'b0};
            ph_p = 2'd1;
          end else if (ph_p == 2'd1) begin
            scl_p = 1'b1;
            ph_p = 2'd2;
          end else begin
            scl_p = 1'b0;
            ph_p = 2'd0;
            nbits_p = nbits_p + 4'd1;
            if (nbits_p >= i2cmbe_pkg::BITS_PER_BYTE) begin
              op_p = i2cmbe_pkg::OP_IDLE;
              nbits_p = 4'd0;
              fin = 1'b1;
            end
          end
        end
        i2cmbe_pkg::OP_READ_ACK, i2cmbe_pkg::OP_READ_NACK: begin
          if (nbits_p < i2cmbe_pkg::BITS_PER_BYTE) begin
            // data bit: sample on the SCL rise, count on the fall
            if (ph_p == 2'd0) begin
              scl_p = 1'b1;
              sh_p = {sh_p[6:0], s};
              ph_p = 2'd1;
            end else begin
              scl_p = 1'b0;
              ph_p = 2'd0;
              nbits_p = nbits_p + 4'd1;
            end
          end else if (ph_p == 2'd0) begin
            drv_p = 1'b1;
            sda_p = (op_p == i2cmbe_pkg::OP_READ_NACK);
            ph_p = 2'd1;
          end else if (ph_p == 2'd1) begin
            scl_p = 1'b1;
            ph_p = 2'd2;
          end else begin
            scl_p = 1'b0;
            ph_p = 2'd0;
            nbits_p = 4'd0;
            rx_p = sh_p;
            op_p = i2cmbe_pkg::OP_IDLE;
            fin = 1'b1;
          end
        end
        i2cmbe_pkg::OP_WAIT: begin
          if (ph_p == 2'd0) begin
            scl_p = 1'b1;
            ph_p = 2'd1;
          end else if (!s) begin
            scl_p = 1'b0;
            op_p = i2cmbe_pkg::OP_IDLE;
            ph_p = 2'd0;
            fin = 1'b1;
          end else if ({1'b0, polls_p} + 9'd1 > {1'b0, limit_p}) begin
            // timed out: flag it and drop into a STOP
            fail_p = 1'b1;
            op_p = i2cmbe_pkg::OP_STOP;
            ph_p = 2'd0;
            drv_p = 1'b1;
            scl_p = 1'b0;
            sda_p = 1'b0;
          end else begin
            polls_p = polls_p + 8'd1;
          end
        end
        default: begin
        end
      endcase
    end else if (c != i2cmbe_pkg::CMD_TICK && c <= i2cmbe_pkg::CMD_LAST
                 && op_p == i2cmbe_pkg::OP_IDLE) begin
      fail_p = 1'b0;
      ph_p = 2'd0;
      nbits_p = 4'd0;
      op_p = i2cmbe_pkg::op_t'(c);
      case (i2cmbe_pkg::op_t'(c))
        i2cmbe_pkg::OP_START: begin
          drv_p = 1'b1;
          sda_p = 1'b1;
          scl_p = 1'b1;
        end
        i2cmbe_pkg::OP_STOP: begin
          drv_p = 1'b1;
          scl_p = 1'b0;
          sda_p = 1'b0;
        end
        i2cmbe_pkg::OP_WRITE: begin
          drv_p = 1'b1;
          scl_p = 1'b0;
          sh_p = b;
        end
        i2cmbe_pkg::OP_READ_ACK, i2cmbe_pkg::OP_READ_NACK: begin
          drv_p = 1'b0;
          scl_p = 1'b0;
          sh_p = 8'h00;
        end
        default: begin
          drv_p = 1'b0;
          sda_p = 1'b1;
          polls_p = 8'h00;
        end
      endcase
    end
    r.scl_level = scl_p;
    r.sda_level = sda_p;
    r.sda_drive = drv_p;
    r.busy_res = (op_p != i2cmbe_pkg::OP_IDLE);
    r.done_res = fin;
    r.read_byte = rx_p;
    r.ack_fail = fail_p;
    return r;
  endfunction

  // Offer one item after an optional gap, hold it until the transfer, then predict
  task automatic push_item(input logic [2:0] c, input logic [7:0] b, input logic s,
                           input logic pinned, input i2cmbe_pkg::res_t want);
    int gap;
    i2cmbe_pkg::res_t r;
    gap = gap_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    write_byte <= b;
    sda_in <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = bus_step(c, b, s);
    want_lines.push_back(pinned ? want : r);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (want_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string fld, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, fld, want, got);
      errors++;
    end
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    i2cmbe_pkg::res_t w;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (want_lines.size() == 0) begin
        $display("%0t: result with nothing expected, actual scl %0b sda %0b read_byte %0h",
                 $time, scl_level, sda_level, read_byte);
        errors++;
      end else begin
        w = want_lines.pop_front();
        check_field("scl_level", 8'(w.scl_level), 8'(scl_level));
        check_field("sda_level", 8'(w.sda_level), 8'(sda_level));
        check_field("sda_drive", 8'(w.sda_drive), 8'(sda_drive));
        check_field("busy_res", 8'(w.busy_res), 8'(busy_res));
        check_field("done_res", 8'(w.done_res), 8'(done_res));
        check_field("read_byte", w.read_byte, read_byte);
        check_field("ack_fail", 8'(w.ack_fail), 8'(ack_fail));
      end
    end
  end

  // Receiver: stall a random number of cycles per transfer, or a long hold when asked
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        hold = stall_on ? $urandom_range(0, 15) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int n;
    int r;
    int ack_after;
    logic [2:0] c;
    logic [7:0] b;
    logic [7:0] lim;
    logic s;
    bit counted;
    ack_after = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // bus idle high after reset
    op_p = i2cmbe_pkg::OP_IDLE;
    ph_p = 2'd0;
    nbits_p = 4'd0;
    sh_p = 8'h00;
    polls_p = 8'h00;
    rx_p = 8'h00;
    limit_p = i2cmbe_pkg::LIMIT_RESET;
    scl_p = 1'b1;
    sda_p = 1'b1;
    drv_p = 1'b1;
    fail_p = 1'b0;

    // Directed rows; the last read is left running for the random part to finish
    for (int i = 0; i < DIR_ROWS; i++) begin
      push_item(DIR_TAB[i].cmd, DIR_TAB[i].wbyte, DIR_TAB[i].sda, DIR_TAB[i].pinned,
                DIR_TAB[i].want);
    end

    for (p = 0; p < PHASES; p++) begin
      gap_on = (p != 2) && (p != 4);
      stall_on = (p != 4) && (p != 5);
      if (p > 0) begin
        settle();
        lim = (p == 3) ? 8'($urandom_range(4, 254)) : CFG_PLAN[p];
        cfg_valid <= 1'b1;
        cfg_data <= lim;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        limit_p = lim;
      end
      // long receiver hold while the sender keeps offering
      if (p == 2) hold_req = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS || op_p != i2cmbe_pkg::OP_IDLE) begin
        counted = 1'b1;
        b = 8'($urandom);
        s = 1'($urandom);
        if (op_p != i2cmbe_pkg::OP_IDLE) begin
          if ($urandom_range(0, 9) == 0) begin
            // command while busy: ignored
            c = 3'($urandom_range(1, 7));
            counted = 1'b0;
          end else begin
            c = i2cmbe_pkg::CMD_TICK;
            if (op_p == i2cmbe_pkg::OP_WAIT && ph_p == 2'd1) s = (polls_p < ack_after);
          end
        end else if ($urandom_range(0, 11) == 0) begin
          c = $urandom_range(0, 1) ? i2cmbe_pkg::CMD_TICK : CMD_RSVD;
          counted = 1'b0;
        end else begin
          c = 3'($urandom_range(1, 6));
          r = $urandom_range(0, 3);
          if (r == 0) b = 8'h00;
          else if (r == 1) b = 8'hFF;
          // ack wait: quick ack mostly, sometimes at or past the timeout edge
          r = $urandom_range(0, 15);
          if (r >= ((limit_p > 8'd16) ? 15 : 10)) begin
            r = $urandom_range(0, 2);
            ack_after = (r == 2) ? ACK_NEVER : int'(limit_p) + r;
          end else begin
            ack_after = $urandom_range(0, 3);
          end
        end
        push_item(c, b, s, 1'b0, '0);
        if (counted) n++;
      end
    end

    settle();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== i2c_master_bit_engine_core.f =====
+incdir+hw/rtl
hw/rtl/i2cmbe_pkg.sv
hw/rtl/i2cmbe_seq.sv
hw/rtl/i2c_master_bit_engine_core.sv
hw/rtl/i2cmbe_chk.sv
tb/sv/tb_i2c_master_bit_engine_core.sv
